### rtl/core/asipu_pkg.sv
`default_nettype none

package asipu_pkg;

   // Default widths of the timeline position, the rates and the sample count
   localparam int DEF_POS_WIDTH   = 48;
   localparam int DEF_RATE_WIDTH  = 20;
   localparam int DEF_COUNT_WIDTH = 32;

   // Both rates come out of reset at this value
   localparam int RATE_RESET = 48000;

   // Width of one multiplicand slice fed to the multiplier
   localparam int MUL_SLICE = 32;

   localparam int STATUS_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_START = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_RATE  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_RATE  = 2'd2;

   // Item mode carried in tuser
   localparam logic MODE_EXTEND = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK          = 3'd0,
      ST_SRC_BAD     = 3'd1,
      ST_RESCALE_OVF = 3'd2,
      ST_BOUND_OVF   = 3'd3,
      ST_NO_ADVANCE  = 3'd4,
      ST_EXTEND_BAD  = 3'd5
   } status_type;

   // Controller to datapath commands, one per step of the sequence
   typedef struct packed {
      logic load;
      logic check;
      logic mul;
      logic acc;
      logic div_init;
      logic div_step;
      logic range_chk;
      logic compare;
      logic emit;
   } cmd_type;

   // Datapath to controller: the result is settled early
   typedef struct packed {
      logic check_done;
      logic range_done;
   } sts_type;

   // Round a bit count up to whole bytes
   function automatic int byte_round(input int bits);
      return ((bits + 7) >> 3) << 3;
   endfunction

endpackage

`default_nettype wire

### rtl/core/audio_sample_interval_projector_unit.sv
// Append beat: the entry check, the slice-by-slice multiply, the divider with one
// quotient bit per cycle, the range check and the advance compare, then the result;
// a projection out of range skips the advance compare.
// Extend beats, rejected counts and a zero source rate: entry check, then the result.
// One beat at a time; the next beat is taken the cycle after the result is registered.
// Synchronous active-high reset: rates 48000, output start 0, timeline restarted.
`default_nettype none

module audio_sample_interval_projector_unit import asipu_pkg::*; #(
   parameter int POS_WIDTH   = DEF_POS_WIDTH,
   parameter int RATE_WIDTH  = DEF_RATE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // sample_count
   input  wire logic [byte_round(COUNT_WIDTH)-1:0]    req_tdata,
   // mode
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // interval_start, interval_end, status, source_total_now
   output logic [byte_round(3*POS_WIDTH+STATUS_WIDTH)-1:0] rsp_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0]            csr_index,
   input  wire logic [POS_WIDTH-1:0]                  csr_wdata
);

   localparam int OUT_WIDTH = byte_round(3*POS_WIDTH + STATUS_WIDTH);

   cmd_type                 cmd;
   sts_type                 sts;
   logic [POS_WIDTH-1:0]    rsp_start;
   logic [POS_WIDTH-1:0]    rsp_end;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [POS_WIDTH-1:0]    rsp_total;

   asipu_ctrl #(
      .POS_WIDTH  (POS_WIDTH),
      .RATE_WIDTH (RATE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   asipu_dp #(
      .POS_WIDTH   (POS_WIDTH),
      .RATE_WIDTH  (RATE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_tuser),
      .req_count  (req_tdata[COUNT_WIDTH-1:0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_start  (rsp_start),
      .rsp_end    (rsp_end),
      .rsp_status (rsp_status),
      .rsp_total  (rsp_total)
   );

   // Pack the result beat, first field lowest
   assign rsp_tdata = OUT_WIDTH'({rsp_total, rsp_status, rsp_end, rsp_start});

endmodule

`default_nettype wire

### rtl/core/asipu_dp.sv
`default_nettype none

module asipu_dp import asipu_pkg::*; #(
   parameter int POS_WIDTH   = DEF_POS_WIDTH,
   parameter int RATE_WIDTH  = DEF_RATE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output sts_type                         sts,
   input  wire logic                       req_mode,
   input  wire logic [COUNT_WIDTH-1:0]     req_count,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [POS_WIDTH-1:0]       csr_wdata,
   output logic [POS_WIDTH-1:0]            rsp_start,
   output logic [POS_WIDTH-1:0]            rsp_end,
   output logic [STATUS_WIDTH-1:0]         rsp_status,
   output logic [POS_WIDTH-1:0]            rsp_total
);

   localparam int WIDE        = ((POS_WIDTH > COUNT_WIDTH) ? POS_WIDTH : COUNT_WIDTH) + 2;
   localparam int PROD_WIDTH  = POS_WIDTH + RATE_WIDTH;
   localparam int MUL_CHUNKS  = (POS_WIDTH + MUL_SLICE - 1) / MUL_SLICE;
   localparam int MCAND_WIDTH = MUL_CHUNKS * MUL_SLICE;
   localparam int PART_WIDTH  = MUL_SLICE + RATE_WIDTH;

   localparam logic [POS_WIDTH-1:0] SIGN_BIT  = {1'b1, {(POS_WIDTH-1){1'b0}}};
   localparam logic [WIDE-1:0]      SMAX_WIDE = {{(WIDE-POS_WIDTH+1){1'b0}},
                                                 {(POS_WIDTH-1){1'b1}}};
   localparam logic [WIDE-1:0]      PMAX_WIDE = {{(WIDE-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};

   // Configuration and running state
   logic [POS_WIDTH-1:0]   out_start_ff;
   logic [RATE_WIDTH-1:0]  rate_src_ff;
   logic [RATE_WIDTH-1:0]  rate_out_ff;
   logic [POS_WIDTH-1:0]   src_total_ff;
   logic [POS_WIDTH-1:0]   out_end_ff;

   // Working registers of one item
   logic                   mode_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [POS_WIDTH-1:0]   total_new_ff;
   logic [MCAND_WIDTH-1:0] mcand_ff;
   logic [PART_WIDTH-1:0]  part_ff;
   logic [PROD_WIDTH-1:0]  acc_ff;
   logic [PROD_WIDTH-1:0]  quot_ff;
   logic [RATE_WIDTH-1:0]  rem_ff;
   logic [POS_WIDTH-1:0]   new_end_ff;
   status_type             status_ff;

   // Output register
   logic [POS_WIDTH-1:0]   rsp_start_ff;
   logic [POS_WIDTH-1:0]   rsp_end_ff;
   status_type             rsp_status_ff;
   logic [POS_WIDTH-1:0]   rsp_total_ff;

   logic [WIDE-1:0]        count_wide;
   logic [WIDE-1:0]        sum_wide;
   logic [WIDE-1:0]        ext_sum;
   logic                   count_bad;
   logic                   src_bad;
   logic                   ext_bad;
   logic                   extend_mode;
   logic                   rate_zero;
   status_type             check_status;
   logic [RATE_WIDTH:0]    trial;
   logic [RATE_WIDTH:0]    trial_diff;
   logic                   div_ge;
   logic [RATE_WIDTH-1:0]  rem_in;
   logic                   quot_ovf;
   logic [POS_WIDTH-1:0]   proj;
   logic [POS_WIDTH:0]     start_sum;
   logic                   bound_bad;
   status_type             range_status;
   logic                   no_advance;
   logic                   item_ok;

   // Entry checks: source count and total range, zero source rate, extend range
   always_comb begin
      extend_mode = (mode_ff == MODE_EXTEND);
      count_wide  = WIDE'(count_ff);
      sum_wide    = WIDE'(src_total_ff) + count_wide;
      ext_sum     = WIDE'(out_end_ff ^ SIGN_BIT) + count_wide;
      count_bad   = (count_ff == '0) || (count_wide > SMAX_WIDE);
      src_bad     = count_bad || (sum_wide > SMAX_WIDE);
      ext_bad     = count_bad || (ext_sum > PMAX_WIDE);
      rate_zero   = (rate_src_ff == '0);
      if (extend_mode) begin
         check_status = ext_bad ? ST_EXTEND_BAD : ST_OK;
      end else if (src_bad) begin
         check_status = ST_SRC_BAD;
      end else if (rate_zero) begin
         check_status = ST_RESCALE_OVF;
      end else begin
         check_status = ST_OK;
      end
   end

   // Restoring divider step, one quotient bit a cycle
   always_comb begin
      trial      = {rem_ff, quot_ff[PROD_WIDTH-1]};
      trial_diff = trial - {1'b0, rate_src_ff};
      div_ge     = (trial >= {1'b0, rate_src_ff});
      rem_in     = div_ge ? trial_diff[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
   end

   // Projection range and new boundary
   always_comb begin
      quot_ovf  = |quot_ff[PROD_WIDTH-1:POS_WIDTH-1];
      proj      = quot_ff[POS_WIDTH-1:0];
      start_sum = {1'b0, out_start_ff ^ SIGN_BIT} + {1'b0, proj};
      bound_bad = (proj == '0) || start_sum[POS_WIDTH];
      if (quot_ovf) begin
         range_status = ST_RESCALE_OVF;
      end else if (bound_bad) begin
         range_status = ST_BOUND_OVF;
      end else begin
         range_status = ST_OK;
      end
   end

   assign no_advance = ($signed(new_end_ff) <= $signed(out_end_ff));
   assign item_ok    = (status_ff == ST_OK);

   assign sts.check_done = extend_mode || src_bad || rate_zero;
   assign sts.range_done = quot_ovf || bound_bad;

   // Configuration and timeline state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_start_ff <= '0;
         rate_src_ff  <= RATE_WIDTH'(RATE_RESET);
         rate_out_ff  <= RATE_WIDTH'(RATE_RESET);
         src_total_ff <= '0;
         out_end_ff   <= '0;
      end else if (csr_we && (csr_index == CSR_OUTPUT_START)) begin
         out_start_ff <= csr_wdata;
         src_total_ff <= '0;
         out_end_ff   <= csr_wdata;
      end else if (csr_we && (csr_index == CSR_SOURCE_RATE)) begin
         rate_src_ff  <= csr_wdata[RATE_WIDTH-1:0];
         src_total_ff <= '0;
         out_end_ff   <= out_start_ff;
      end else if (csr_we && (csr_index == CSR_OUTPUT_RATE)) begin
         rate_out_ff  <= csr_wdata[RATE_WIDTH-1:0];
         src_total_ff <= '0;
         out_end_ff   <= out_start_ff;
      end else if (cmd.emit && item_ok) begin
         out_end_ff <= new_end_ff;
         if (!extend_mode) begin
            src_total_ff <= total_new_ff;
         end
      end
   end

   // Item working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         count_ff <= req_count;
      end
      if (cmd.check) begin
         status_ff    <= check_status;
         new_end_ff   <= ext_sum[POS_WIDTH-1:0] ^ SIGN_BIT;
         total_new_ff <= sum_wide[POS_WIDTH-1:0];
         mcand_ff     <= MCAND_WIDTH'(sum_wide[POS_WIDTH-1:0]);
         acc_ff       <= '0;
      end
      // multiply one slice, most significant first
      if (cmd.mul) begin
         part_ff  <= mcand_ff[MCAND_WIDTH-1 -: MUL_SLICE] * rate_out_ff;
         mcand_ff <= mcand_ff << MUL_SLICE;
      end
      if (cmd.acc) begin
         acc_ff <= (acc_ff << MUL_SLICE) + PROD_WIDTH'(part_ff);
      end
      // add half the divisor for rounding, then divide
      if (cmd.div_init) begin
         quot_ff <= acc_ff + PROD_WIDTH'(rate_src_ff >> 1);
         rem_ff  <= '0;
      end
      if (cmd.div_step) begin
         quot_ff <= {quot_ff[PROD_WIDTH-2:0], div_ge};
         rem_ff  <= rem_in;
      end
      if (cmd.range_chk) begin
         status_ff  <= range_status;
         new_end_ff <= start_sum[POS_WIDTH-1:0] ^ SIGN_BIT;
      end
      if (cmd.compare) begin
         status_ff <= no_advance ? ST_NO_ADVANCE : ST_OK;
      end
   end

   // Result beat
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_start_ff  <= out_end_ff;
         rsp_end_ff    <= item_ok ? new_end_ff : out_end_ff;
         rsp_status_ff <= status_ff;
         rsp_total_ff  <= (item_ok && !extend_mode) ? total_new_ff : src_total_ff;
      end
   end

   assign rsp_start  = rsp_start_ff;
   assign rsp_end    = rsp_end_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_total  = rsp_total_ff;

endmodule

`default_nettype wire

### rtl/core/asipu_ctrl.sv
`default_nettype none

module asipu_ctrl import asipu_pkg::*; #(
   parameter int POS_WIDTH  = DEF_POS_WIDTH,
   parameter int RATE_WIDTH = DEF_RATE_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam int MUL_CHUNKS = (POS_WIDTH + MUL_SLICE - 1) / MUL_SLICE;
   localparam int DIV_STEPS  = POS_WIDTH + RATE_WIDTH;
   localparam int CHUNK_CW   = $clog2(MUL_CHUNKS + 1);
   localparam int STEP_CW    = $clog2(DIV_STEPS);

   localparam logic [CHUNK_CW-1:0] LAST_CHUNK = CHUNK_CW'(MUL_CHUNKS - 1);
   localparam logic [STEP_CW-1:0]  LAST_STEP  = STEP_CW'(DIV_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL,
      S_ACC,
      S_DIV_INIT,
      S_DIV,
      S_RANGE,
      S_COMPARE,
      S_OUT
   } state_type;

   state_type             state_ff;
   logic                  req_tready_ff;
   logic                  rsp_tvalid_ff;
   logic [CHUNK_CW-1:0]   chunk_ff;
   logic [STEP_CW-1:0]    step_ff;
   logic                  accept;
   logic                  out_free;

   assign accept   = req_tvalid && req_tready_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Command decode
   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.check     = (state_ff == S_CHECK);
      cmd.mul       = (state_ff == S_MUL);
      cmd.acc       = (state_ff == S_ACC);
      cmd.div_init  = (state_ff == S_DIV_INIT);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.range_chk = (state_ff == S_RANGE);
      cmd.compare   = (state_ff == S_COMPARE);
      cmd.emit      = (state_ff == S_OUT) && out_free;
   end

   // Sequencer, handshake flags and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
         chunk_ff      <= '0;
         step_ff       <= '0;
      end else begin
         if (cmd.emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff      <= S_CHECK;
                  req_tready_ff <= 1'b0;
               end
            end
            S_CHECK: begin
               chunk_ff <= '0;
               state_ff <= sts.check_done ? S_OUT : S_MUL;
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (chunk_ff == LAST_CHUNK) begin
                  state_ff <= S_DIV_INIT;
               end else begin
                  chunk_ff <= chunk_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_DIV_INIT: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_RANGE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_RANGE: begin
               state_ff <= sts.range_done ? S_OUT : S_COMPARE;
            end
            S_COMPARE: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= S_IDLE;
               req_tready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

### rtl/core/asipu_chk.sv
`default_nettype none

module asipu_chk import asipu_pkg::*; #(
   parameter int POS_WIDTH = DEF_POS_WIDTH
) (
   input wire logic                                       clock,
   input wire logic                                       reset,
   input wire logic                                       req_tvalid,
   input wire logic                                       req_tready,
   input wire logic                                       rsp_tvalid,
   input wire logic                                       rsp_tready,
   input wire logic [byte_round(3*POS_WIDTH+STATUS_WIDTH)-1:0] rsp_tdata
);

   logic [POS_WIDTH-1:0]    chk_start;
   logic [POS_WIDTH-1:0]    chk_end;
   logic [STATUS_WIDTH-1:0] chk_status;

   assign chk_start  = rsp_tdata[POS_WIDTH-1:0];
   assign chk_end    = rsp_tdata[2*POS_WIDTH-1:POS_WIDTH];
   assign chk_status = rsp_tdata[2*POS_WIDTH +: STATUS_WIDTH];

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // One item in flight: intake closes after a beat is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   // A rejected item leaves an empty interval at the old end
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chk_status != ST_OK) |-> (chk_start == chk_end))
      else $error("failed item reports a non-empty interval");

   // A successful item always moves the end forward
   a_ok_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chk_status == ST_OK) |-> ($signed(chk_end) > $signed(chk_start)))
      else $error("successful interval does not advance");

endmodule

bind audio_sample_interval_projector_unit asipu_chk #(
   .POS_WIDTH (POS_WIDTH)
) u_asipu_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench import asipu_pkg::*;;

   localparam int POS_W   = DEF_POS_WIDTH;
   localparam int RATE_W  = DEF_RATE_WIDTH;
   localparam int COUNT_W = DEF_COUNT_WIDTH;
   localparam int REQ_W   = byte_round(COUNT_W);
   localparam int RSP_W   = byte_round(3*POS_W+STATUS_WIDTH);

   // Index with no register behind it: writes must be ignored
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam logic MODE_APPEND = ~MODE_EXTEND;

   localparam logic [63:0]      POS_MASK = (64'd1 << POS_W) - 64'd1;
   localparam logic [63:0]      POS_SMAX = (64'd1 << (POS_W-1)) - 64'd1;
   localparam logic [POS_W-1:0] POS_SIGN = {1'b1, {(POS_W-1){1'b0}}};

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_BLOCKS    = 88;

   typedef struct packed {
      logic [POS_W-1:0] iv_start;
      logic [POS_W-1:0] iv_stop;
      status_type       status;
      logic [POS_W-1:0] src_total;
   } interval_rsp_type;

   typedef struct packed {
      logic               mode;
      logic [COUNT_W-1:0] count;
   } audio_block_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;   // sample_count
   logic               req_tuser  = 1'b0; // mode
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;         // interval_start, interval_end, status, source_total_now
   logic               csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [POS_W-1:0]   csr_wdata  = '0;

   audio_sample_interval_projector_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow registers and timeline state
   logic [POS_W-1:0]  cfg_out_start;
   logic [RATE_W-1:0] cfg_src_rate;
   logic [RATE_W-1:0] cfg_out_rate;
   logic [POS_W-1:0]  tl_src_total;
   logic [POS_W-1:0]  tl_out_end;

   audio_block_type  pending_blocks[$];
   interval_rsp_type expected_intervals[$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  idle_on        = 1'b1;
   bit  rx_hold_arm    = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Signed position plus a forward amount; fails on zero, oversize or wrap
   function automatic logic advance_pos(input logic [POS_W-1:0] base,
                                        input logic [63:0] amount,
                                        output logic [POS_W-1:0] sum);
      logic [POS_W-1:0] biased;
      biased = base ^ POS_SIGN;
      sum    = base;
      if (amount == 64'd0 || amount > POS_SMAX || 64'(biased) > POS_MASK - amount)
         return 1'b0;
      sum = base + amount[POS_W-1:0];
      return 1'b1;
   endfunction

   // (total*out_rate + src_rate/2) / src_rate, fails on zero divisor or overflow
   function automatic logic rescale_total(input logic [POS_W-1:0] total,
                                          output logic [POS_W-1:0] proj);
      logic [127:0] num;
      logic [127:0] quo;
      proj = '0;
      if (cfg_src_rate == '0)
         return 1'b0;
      num = 128'(total) * 128'(cfg_out_rate) + 128'(cfg_src_rate >> 1);
      quo = num / 128'(cfg_src_rate);
      if (quo > 128'(POS_SMAX))
         return 1'b0;
      proj = quo[POS_W-1:0];
      return 1'b1;
   endfunction

   // Advances the shadow timeline by one block and returns its interval
   function automatic interval_rsp_type project_block(input audio_block_type blk);
      interval_rsp_type r;
      status_type       st;
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] total;
      logic [POS_W-1:0] proj;
      logic [POS_W-1:0] new_end;
      prev    = tl_out_end;
      st      = ST_OK;
      new_end = '0;
      total   = '0;
      if (blk.mode != MODE_EXTEND) begin
         if (blk.count == '0 || 64'(blk.count) > POS_SMAX ||
             64'(tl_src_total) > POS_SMAX - 64'(blk.count)) begin
            st = ST_SRC_BAD;
         end else begin
            total = tl_src_total + POS_W'(blk.count);
            if (!rescale_total(total, proj))
               st = ST_RESCALE_OVF;
            else if (!advance_pos(cfg_out_start, 64'(proj), new_end))
               st = ST_BOUND_OVF;
            else if ($signed(new_end) <= $signed(tl_out_end))
               st = ST_NO_ADVANCE;
         end
         if (st == ST_OK) begin
            tl_src_total = total;
            tl_out_end   = new_end;
         end
      end else if (!advance_pos(tl_out_end, 64'(blk.count), new_end)) begin
         st = ST_EXTEND_BAD;
      end else begin
         tl_out_end = new_end;
      end
      r.iv_start  = prev;
      r.iv_stop   = (st == ST_OK) ? new_end : prev;
      r.status    = st;
      r.src_total = tl_src_total;
      return r;
   endfunction

   function automatic logic [RATE_W-1:0] pick_rate();
      int unsigned std_rates[6] = '{8000, 22050, 44100, 48000, 96000, 192000};
      int unsigned sel;
      sel = $urandom_range(0, 8);
      if (sel < 6)
         return RATE_W'(std_rates[sel]);
      else if (sel == 6)
         return RATE_W'(1);
      else if (sel == 7)
         return '1;
      return RATE_W'($urandom_range(1, (1 << RATE_W) - 1));
   endfunction

   // Register write; any known index restarts the shadow timeline
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [POS_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx != CSR_SPARE) begin
         case (idx)
            CSR_OUTPUT_START: cfg_out_start = val;
            CSR_SOURCE_RATE:  cfg_src_rate  = val[RATE_W-1:0];
            default:          cfg_out_rate  = val[RATE_W-1:0];
         endcase
         tl_src_total = '0;
         tl_out_end   = cfg_out_start;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_block(input logic mode, input logic [COUNT_W-1:0] count);
      audio_block_type blk;
      blk.mode  = mode;
      blk.count = count;
      pending_blocks.push_back(blk);
   endtask

   // Sampled on the falling edge so that the driver and monitor have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_blocks.size() != 0 || req_tvalid || expected_intervals.size() != 0);
   endtask

   // Input side: one beat per queued block, with random gaps while idle_on is set
   int send_gap = 0;
   always @(posedge clock) begin
      audio_block_type blk;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_blocks.size() != 0) begin
            blk = pending_blocks.pop_front();
            req_tdata  <= REQ_W'(blk.count);
            req_tuser  <= blk.mode;
            req_tvalid <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
               send_gap <= $urandom_range(1, 5);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: random stall bursts while idle_on is set, plus one long hold-off
   int  stall_left   = 0;
   int  hold_left    = 0;
   bit  rx_hold_used = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_arm && !rx_hold_used) begin
         rx_hold_used <= 1'b1;
         hold_left    <= HOLD_OFF_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Prediction on accepted blocks, checking on accepted results
   always @(posedge clock) begin
      interval_rsp_type want;
      interval_rsp_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[POS_W-1:0], rsp_tdata[2*POS_W-1:POS_W],
                   status_type'(rsp_tdata[2*POS_W+STATUS_WIDTH-1:2*POS_W]),
                   rsp_tdata[3*POS_W+STATUS_WIDTH-1:2*POS_W+STATUS_WIDTH]};
            if (expected_intervals.size() == 0) begin
               $error("result beat with nothing expected");
               mismatch_count++;
            end else begin
               want = expected_intervals.pop_front();
               if (got.iv_start !== want.iv_start) begin
                  $error("interval_start: expected %0d, got %0d",
                         $signed(want.iv_start), $signed(got.iv_start));
                  mismatch_count++;
               end
               if (got.iv_stop !== want.iv_stop) begin
                  $error("interval_end: expected %0d, got %0d",
                         $signed(want.iv_stop), $signed(got.iv_stop));
                  mismatch_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatch_count++;
               end
               if (got.src_total !== want.src_total) begin
                  $error("source_total_now: expected %0d, got %0d",
                         want.src_total, got.src_total);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_intervals.push_back(
               project_block({req_tuser, req_tdata[COUNT_W-1:0]}));
      end
   end

   // Watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** audio_sample_interval_projector_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Phases of stimulus
   initial begin
      logic [COUNT_W-1:0] cnt;
      logic [POS_W-1:0]   start;
      logic               mode;
      cfg_out_start = '0;
      cfg_src_rate  = RATE_W'(RATE_RESET);
      cfg_out_rate  = RATE_W'(RATE_RESET);
      tl_src_total  = '0;
      tl_out_end    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults, 1:1 rates: zero counts, extremes, end not advancing
      @(negedge clock);
      queue_block(MODE_APPEND, '0);
      queue_block(MODE_EXTEND, '0);
      queue_block(MODE_APPEND, 32'd1);
      queue_block(MODE_APPEND, '1);
      queue_block(MODE_EXTEND, '1);
      queue_block(MODE_APPEND, 32'd1000);
      queue_block(MODE_EXTEND, 32'd1);
      queue_block(MODE_APPEND, 32'd1);
      wait_drained();

      // Spare index is ignored; then start just below the top of the range
      write_reg(CSR_SPARE, POS_W'({$urandom, $urandom}));
      write_reg(CSR_OUTPUT_START, POS_W'(POS_SMAX - 64'd10));
      @(negedge clock);
      queue_block(MODE_APPEND, 32'd5);
      queue_block(MODE_APPEND, 32'd10);
      queue_block(MODE_EXTEND, 32'd5);
      queue_block(MODE_EXTEND, 32'd1);
      wait_drained();

      // Most negative start, steep upscale with junk above the rate field
      write_reg(CSR_OUTPUT_START, POS_SIGN);
      write_reg(CSR_SOURCE_RATE, {28'hFFF_FFFF, 20'd1});
      write_reg(CSR_OUTPUT_RATE, {28'hFFF_FFFF, 20'hF_FFFF});
      @(negedge clock);
      queue_block(MODE_APPEND, '1);
      queue_block(MODE_APPEND, 32'd1);
      queue_block(MODE_APPEND, 32'h0800_0000);
      queue_block(MODE_APPEND, 32'h0800_0000);
      wait_drained();

      // Steep downscale: zero projection, then a projection that stalls
      write_reg(CSR_OUTPUT_START, '0);
      write_reg(CSR_SOURCE_RATE, POS_W'(20'hF_FFFF));
      write_reg(CSR_OUTPUT_RATE, POS_W'(1));
      @(negedge clock);
      queue_block(MODE_APPEND, 32'd1);
      queue_block(MODE_APPEND, 32'd600000);
      queue_block(MODE_APPEND, 32'd100);
      wait_drained();

      // Zero output rate, then zero source rate
      write_reg(CSR_OUTPUT_RATE, '0);
      @(negedge clock);
      queue_block(MODE_APPEND, 32'd5);
      queue_block(MODE_EXTEND, 32'd7);
      wait_drained();
      write_reg(CSR_OUTPUT_RATE, POS_W'(48000));
      write_reg(CSR_SOURCE_RATE, '0);
      @(negedge clock);
      queue_block(MODE_APPEND, 32'd5);
      queue_block(MODE_EXTEND, 32'd3);
      wait_drained();

      // Random phases, each under a fresh setting; the last without idling
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0: start = '0;
            1: start = POS_W'({$urandom, $urandom});
            2: start = POS_W'(POS_SMAX - 64'($urandom_range(0, 1 << 20)));
            3: start = POS_SIGN + POS_W'($urandom);
            4: start = '0 - POS_W'($urandom_range(0, 1000000));
            default: start = POS_W'($urandom_range(0, 1000000));
         endcase
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_SPARE, POS_W'({$urandom, $urandom}));
         write_reg(CSR_SOURCE_RATE, {28'($urandom), pick_rate()});
         write_reg(CSR_OUTPUT_RATE, {28'($urandom), pick_rate()});
         write_reg(CSR_OUTPUT_START, start);
         @(negedge clock);
         idle_on = (ph != RANDOM_PHASES - 1);
         if (ph == 1)
            rx_hold_arm = 1'b1;
         for (int i = 0; i < PHASE_BLOCKS; i++) begin
            case ($urandom_range(0, 19))
               0:       cnt = '0;
               1, 2, 3: cnt = $urandom;
               4, 5, 6, 7: cnt = $urandom_range(1, 65535);
               default: cnt = $urandom_range(1, 4096);
            endcase
            mode = ($urandom_range(0, 3) == 0) ? MODE_EXTEND : MODE_APPEND;
            queue_block(mode, cnt);
            // Halfway through one phase the sender waits for every result
            if (ph == 2 && i == PHASE_BLOCKS/2)
               wait_drained();
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_intervals.size() == 0)
         $display("** audio_sample_interval_projector_unit: PASSED **");
      else
         $display("** audio_sample_interval_projector_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/asipu_pkg.sv
rtl/core/asipu_dp.sv
rtl/core/asipu_ctrl.sv
rtl/core/audio_sample_interval_projector_unit.sv
rtl/core/asipu_chk.sv
tb/testbench.sv
